// ----- design/hvt_pkg.sv -----
// Shared types and constants of the homogeneous vertex transform unit.
// Used by the top level, the divider pipeline and the port checker.
`default_nettype none

package hvt_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS_DEF = 16;
    localparam int COMP_W        = 32;
    localparam int NUM_COMP      = 4;
    localparam int TDATA_W       = COMP_W * NUM_COMP;
    localparam int TUSER_W       = 2;

    // Flag positions in tuser
    localparam int TUSER_DIV = 0;
    localparam int TUSER_SAT = 1;

    // Configuration port
    localparam int NUM_REGS = 8;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 64;

    // Matrix register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_ROW0_COLS01 = 3'd0,
        REG_ROW0_COLS23 = 3'd1,
        REG_ROW1_COLS01 = 3'd2,
        REG_ROW1_COLS23 = 3'd3,
        REG_ROW2_COLS01 = 3'd4,
        REG_ROW2_COLS23 = 3'd5,
        REG_ROW3_COLS01 = 3'd6,
        REG_ROW3_COLS23 = 3'd7
    } hvt_reg_t;

    // Sideband that rides along the divider pipeline
    typedef struct packed {
        logic                                 div;
        logic                                 sat;
        logic [2:0]                           neg;
        logic [NUM_COMP-1:0][COMP_W-1:0]      r;
    } hvt_side_t;

endpackage

`default_nettype wire

// ----- design/hvt_div_pipe.sv -----
// Pipelined restoring divider for the x, y and z quotients, one quotient bit per stage.
// Depends on hvt_pkg for the component width and the sideband struct.
`default_nettype none

module hvt_div_pipe #(
    parameter int NW = 48
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [2:0][NW-1:0]         in_num,
    input  wire logic [hvt_pkg::COMP_W-1:0] in_den,
    input  wire hvt_pkg::hvt_side_t         in_side,
    output logic                            out_valid,
    output logic [2:0][NW-1:0]              out_quo,
    output hvt_pkg::hvt_side_t              out_side
);
    import hvt_pkg::*;

    logic [2:0][COMP_W-1:0] rem_reg  [NW];
    logic [2:0][NW-1:0]     num_reg  [NW];
    logic [COMP_W-1:0]      den_reg  [NW];
    hvt_side_t              side_reg [NW];
    logic                   vld_reg  [NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [2:0][COMP_W-1:0] rem_prev;
        logic [2:0][NW-1:0]     num_prev;
        logic [COMP_W-1:0]      den_prev;
        hvt_side_t              side_prev;
        logic                   vld_prev;
        logic [2:0][COMP_W-1:0] rem_next;
        logic [2:0][NW-1:0]     num_next;

        if (i == 0) begin : g_first
            assign rem_prev  = '0;
            assign num_prev  = in_num;
            assign den_prev  = in_den;
            assign side_prev = in_side;
            assign vld_prev  = in_valid;
        end else begin : g_rest
            assign rem_prev  = rem_reg[i-1];
            assign num_prev  = num_reg[i-1];
            assign den_prev  = den_reg[i-1];
            assign side_prev = side_reg[i-1];
            assign vld_prev  = vld_reg[i-1];
        end

        // Shift in the next numerator bit, subtract when it fits
        always_comb begin
            logic [COMP_W:0] rem_sh;
            logic            ge;
            rem_sh   = '0;
            ge       = 1'b0;
            rem_next = '0;
            num_next = '0;
            for (int c = 0; c < 3; c++) begin
                rem_sh = {rem_prev[c], num_prev[c][NW-1]};
                ge     = (rem_sh >= {1'b0, den_prev});
                rem_next[c] = ge ? COMP_W'(rem_sh - {1'b0, den_prev}) : rem_sh[COMP_W-1:0];
                num_next[c] = {num_prev[c][NW-2:0], ge};
            end
        end

        // Advance the stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                num_reg[i]  <= num_next;
                den_reg[i]  <= den_prev;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign out_quo   = num_reg[NW-1];
    assign out_side  = side_reg[NW-1];

endmodule

`default_nettype wire

// ----- design/homogeneous_vertex_transform_unit.sv -----
// Homogeneous 4x4 vertex transform with perspective divide, Q(32-F).F fixed point.
// Top level; depends on hvt_pkg and hvt_div_pipe.
//
// One vertex (x, y, z, w) is taken per transfer and multiplied as a row vector by the
// 4x4 matrix held in eight 64-bit registers (identity after reset). Sums are floored by
// FRAC_BITS and clamped to 32 bits; when w is neither 0 nor 1.0 the x, y and z results
// are divided by w (truncated toward zero, clamped) and w becomes 1.0. The unit takes
// one vertex every cycle unless the result side stalls, which holds the whole pipeline.
// Each result passes four stages of multiply, sum, clamp and operand setup, then the
// divider, which resolves one quotient bit per stage over 32 + FRAC_BITS stages, and
// then the output register. The default format is Q16.16. The user must write the
// matrix registers only while no vertex is in flight; the unit does not enforce this.
`default_nettype none

module homogeneous_vertex_transform_unit #(
    parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // Configuration write port
    input  wire logic                        cfg_we,
    input  wire logic [hvt_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [hvt_pkg::CFG_DW-1:0]  cfg_wdata,
    // Vertex input
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [hvt_pkg::TDATA_W-1:0] s_tdata,  // in_x, in_y, in_z, in_w
    // Result output
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [hvt_pkg::TDATA_W-1:0]      m_tdata,  // out_x, out_y, out_z, out_w
    output logic [hvt_pkg::TUSER_W-1:0]      m_tuser   // was_divided, saturated
);
    import hvt_pkg::*;

    localparam int NW  = COMP_W + FRAC_BITS;
    localparam int SW  = 2 * COMP_W + 2;
    localparam logic [COMP_W-1:0] ONE = COMP_W'(1) << FRAC_BITS;
    localparam logic signed [SW-1:0] SUM_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SUM_MIN = SW'(-64'sd2147483648);
    localparam logic [NW-1:0] Q_MAX_POS = NW'(64'h7FFF_FFFF);
    localparam logic [NW-1:0] Q_MAX_NEG = NW'(64'h8000_0000);
    localparam logic [COMP_W-1:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [COMP_W-1:0] C_MIN = 32'h8000_0000;

    logic en;

    // Matrix registers
    logic [CFG_DW-1:0] mat_reg [NUM_REGS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg[REG_ROW0_COLS01] <= CFG_DW'(ONE);
            mat_reg[REG_ROW0_COLS23] <= '0;
            mat_reg[REG_ROW1_COLS01] <= {ONE, {COMP_W{1'b0}}};
            mat_reg[REG_ROW1_COLS23] <= '0;
            mat_reg[REG_ROW2_COLS01] <= '0;
            mat_reg[REG_ROW2_COLS23] <= CFG_DW'(ONE);
            mat_reg[REG_ROW3_COLS01] <= '0;
            mat_reg[REG_ROW3_COLS23] <= {ONE, {COMP_W{1'b0}}};
        end else if (cfg_we) begin
            mat_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // Advance everything when the output register is free or being drained
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage A: sixteen products
    logic                    va_reg;
    logic signed [63:0]      prod_reg  [4][4];
    logic signed [63:0]      prod_next [4][4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int c = 0; c < 4; c++) begin
                prod_next[k][c] = $signed(s_tdata[k*COMP_W +: COMP_W])
                    * $signed(mat_reg[2*k + c/2][(c%2)*COMP_W +: COMP_W]);
            end
        end
    end

    // Stage B: column sums at full precision
    logic                    vb_reg;
    logic signed [SW-1:0]    sum_reg  [4];
    logic signed [SW-1:0]    sum_next [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            sum_next[c] = '0;
            for (int k = 0; k < 4; k++) begin
                sum_next[c] = sum_next[c] + {{2{prod_reg[k][c][63]}}, prod_reg[k][c]};
            end
        end
    end

    // Stage C: floor shift and clamp
    logic                    vc_reg;
    logic [3:0][COMP_W-1:0]  r_reg;
    logic                    satc_reg;
    logic [3:0][COMP_W-1:0]  r_next;
    logic                    satc_next;

    always_comb begin
        logic signed [SW-1:0] t;
        t         = '0;
        satc_next = 1'b0;
        for (int c = 0; c < 4; c++) begin
            t = sum_reg[c] >>> FRAC_BITS;
            if (t > SUM_MAX) begin
                r_next[c] = C_MAX;
                satc_next = 1'b1;
            end else if (t < SUM_MIN) begin
                r_next[c] = C_MIN;
                satc_next = 1'b1;
            end else begin
                r_next[c] = t[COMP_W-1:0];
            end
        end
    end

    // Stage D: divide decision and divider operands
    logic                    vd_reg;
    logic [2:0][NW-1:0]      num_reg;
    logic [COMP_W-1:0]       den_reg;
    hvt_side_t               side_reg;
    logic [2:0][NW-1:0]      num_next;
    logic [COMP_W-1:0]       den_next;
    hvt_side_t               side_next;

    always_comb begin
        logic [COMP_W-1:0] mag;
        mag = '0;
        for (int c = 0; c < 3; c++) begin
            mag = r_reg[c][COMP_W-1] ? (~r_reg[c] + 1'b1) : r_reg[c];
            num_next[c]      = {mag, {FRAC_BITS{1'b0}}};
            side_next.neg[c] = r_reg[c][COMP_W-1] ^ r_reg[3][COMP_W-1];
        end
        den_next      = r_reg[3][COMP_W-1] ? (~r_reg[3] + 1'b1) : r_reg[3];
        side_next.div = (r_reg[3] != '0) && (r_reg[3] != ONE);
        side_next.sat = satc_reg;
        side_next.r   = r_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
            r_reg    <= r_next;
            satc_reg <= satc_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    // Quotients
    logic               vq;
    logic [2:0][NW-1:0] quo;
    hvt_side_t          side_q;

    hvt_div_pipe #(
        .NW (NW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vd_reg),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .in_side   (side_reg),
        .out_valid (vq),
        .out_quo   (quo),
        .out_side  (side_q)
    );

    // Stage E: sign, clamp and select into the output register
    logic [TDATA_W-1:0] tdata_next;
    logic [TUSER_W-1:0] tuser_next;

    always_comb begin
        logic sat;
        sat        = side_q.sat;
        tdata_next = side_q.r;
        if (side_q.div) begin
            for (int c = 0; c < 3; c++) begin
                if (side_q.neg[c]) begin
                    if (quo[c] > Q_MAX_NEG) begin
                        tdata_next[c*COMP_W +: COMP_W] = C_MIN;
                        sat = 1'b1;
                    end else begin
                        tdata_next[c*COMP_W +: COMP_W] = ~quo[c][COMP_W-1:0] + 1'b1;
                    end
                end else begin
                    if (quo[c] > Q_MAX_POS) begin
                        tdata_next[c*COMP_W +: COMP_W] = C_MAX;
                        sat = 1'b1;
                    end else begin
                        tdata_next[c*COMP_W +: COMP_W] = quo[c][COMP_W-1:0];
                    end
                end
            end
            tdata_next[3*COMP_W +: COMP_W] = ONE;
        end
        tuser_next            = '0;
        tuser_next[TUSER_DIV] = side_q.div;
        tuser_next[TUSER_SAT] = sat;
    end

    logic               m_tvalid_reg;
    logic [TDATA_W-1:0] m_tdata_reg;
    logic [TUSER_W-1:0] m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vq;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= tdata_next;
            m_tuser_reg <= tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ----- design/hvt_checker.sv -----
// Port-level checks of the homogeneous vertex transform unit, bound to its top level.
// Depends on hvt_pkg for widths and flag positions.
`default_nettype none

module hvt_checker #(
    parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [hvt_pkg::TDATA_W-1:0] m_tdata,
    input wire logic [hvt_pkg::TUSER_W-1:0] m_tuser
);
    import hvt_pkg::*;

    localparam logic [COMP_W-1:0] ONE = COMP_W'(1) << FRAC_BITS;

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A divided result carries w of 1.0
    a_div_w: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[TUSER_DIV] |-> m_tdata[3*COMP_W +: COMP_W] == ONE)
        else $error("divided result w is not 1.0");

    // An undivided result has w of 0 or 1.0
    a_nodiv_w: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[TUSER_DIV] |->
            (m_tdata[3*COMP_W +: COMP_W] == '0) || (m_tdata[3*COMP_W +: COMP_W] == ONE))
        else $error("undivided result with w other than 0 or 1.0");

    // Accept input while the output register is empty
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind homogeneous_vertex_transform_unit hvt_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_hvt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
